/* rtl/core/cell_grid_dirty_span_finder_core_assert.svh */
// Assertion macros used by the span finder top level.
`ifndef CELL_GRID_DIRTY_SPAN_FINDER_CORE_ASSERT_SVH
`define CELL_GRID_DIRTY_SPAN_FINDER_CORE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define CGDS_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define CGDS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/cgds_pkg.sv */
// Types, constants and register codes of the dirty span finder.
package cgds_pkg;

  localparam int MAX_COLUMNS_DEF = 1024;
  localparam int MAX_ROWS_DEF    = 1024;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_ROW_STRIDE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_VISIBLE_WIDTH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SPAN_CAP      = 2'd2;

  localparam logic [10:0] ROW_STRIDE_RST    = 11'd80;
  localparam logic [10:0] VISIBLE_WIDTH_RST = 11'd0;
  localparam logic [15:0] SPAN_CAP_RST      = 16'd1024;

  localparam int OUT_COL_W = 10;
  localparam int OUT_ROW_W = 10;
  localparam int OUT_LEN_W = 11;
  localparam int TOTAL_W   = 16;

  localparam logic RESULT_SPAN    = 1'b0;
  localparam logic RESULT_SUMMARY = 1'b1;

  typedef struct packed {
    logic [31:0] new_code_point;
    logic [31:0] new_foreground;
    logic [31:0] new_background;
    logic [15:0] new_attributes;
    logic [7:0]  new_cell_width;
    logic [31:0] old_code_point;
    logic [31:0] old_foreground;
    logic [31:0] old_background;
    logic [15:0] old_attributes;
    logic [7:0]  old_cell_width;
    logic        final_cell;
  } cell_pair_t;

  typedef struct packed {
    logic                 result_kind;
    logic [OUT_COL_W-1:0] span_column;
    logic [OUT_ROW_W-1:0] span_row;
    logic [OUT_LEN_W-1:0] span_length;
    logic [TOTAL_W-1:0]   spans_emitted;
    logic                 overflowed;
    logic                 last_of_run;
  } span_result_t;

  typedef struct packed {
    logic [10:0] row_stride;
    logic [10:0] visible_width;
    logic [15:0] span_cap;
  } cfg_t;

  // compare stage toward run tracker and result buffer
  typedef struct packed {
    logic adv;
    logic diff;
    logic final_cell;
  } cmp_t;

  typedef struct packed {
    span_result_t [2:0] slot;
    logic [1:0]         count;
  } res_bundle_t;

endpackage

/* rtl/core/cgds_if.sv */
// Valid/ready channel interfaces for cell pairs and span results.
interface cgds_cell_if;
  import cgds_pkg::*;
  logic       valid;
  logic       ready;
  cell_pair_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface cgds_span_if;
  import cgds_pkg::*;
  logic         valid;
  logic         ready;
  span_result_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* rtl/core/cgds_cmp.sv */
// Input register: cell compare result and final flag.
module cgds_cmp (
  input  logic                clk_i,
  input  logic                rst_ni,
  cgds_cell_if.sink           cell_i,
  input  logic                room_i,
  output cgds_pkg::cmp_t      cmp_o
);
  import cgds_pkg::*;

  logic vld_q, vld_d;
  logic diff_q, diff_d;
  logic fin_q, fin_d;
  logic take;
  logic diff_in;

  assign diff_in = (cell_i.data.new_code_point != cell_i.data.old_code_point)
                || (cell_i.data.new_foreground != cell_i.data.old_foreground)
                || (cell_i.data.new_background != cell_i.data.old_background)
                || (cell_i.data.new_attributes != cell_i.data.old_attributes)
                || (cell_i.data.new_cell_width != cell_i.data.old_cell_width);

  assign cell_i.ready = !vld_q || room_i;
  assign take         = cell_i.valid && cell_i.ready;

  always_comb begin
    vld_d  = vld_q;
    diff_d = diff_q;
    fin_d  = fin_q;
    if (take) begin
      vld_d  = 1'b1;
      diff_d = diff_in;
      fin_d  = cell_i.data.final_cell;
    end else if (vld_q && room_i) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    diff_q <= diff_d;
    fin_q  <= fin_d;
  end

  assign cmp_o.adv        = vld_q && room_i;
  assign cmp_o.diff       = diff_q;
  assign cmp_o.final_cell = fin_q;

endmodule

/* rtl/core/cgds_run.sv */
// Run tracker: position counters, open run, span count and result list.
module cgds_run #(
  parameter int MAX_COLUMNS = cgds_pkg::MAX_COLUMNS_DEF,
  parameter int MAX_ROWS    = cgds_pkg::MAX_ROWS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  cgds_pkg::cmp_t       cmp_i,
  input  cgds_pkg::cfg_t       cfg_i,
  output cgds_pkg::res_bundle_t bundle_o
);
  import cgds_pkg::*;

  localparam int COL_W = $clog2(MAX_COLUMNS);
  localparam int ROW_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int LEN_W = $clog2(MAX_COLUMNS + 1);
  localparam int SW    = ((COL_W > 11) ? COL_W : 11) + 1;
  localparam int CW    = ((COL_W > LEN_W) ? COL_W : LEN_W) + 1;
  localparam logic [SW-1:0]    MAXC     = SW'(MAX_COLUMNS);
  localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(MAX_ROWS - 1);

  logic [COL_W-1:0]   col_q, col_d;
  logic [ROW_W-1:0]   row_q, row_d;
  logic               open_q, open_d;
  logic [COL_W-1:0]   rstart_q, rstart_d;
  logic [ROW_W-1:0]   rrow_q, rrow_d;
  logic [LEN_W-1:0]   rlen_q, rlen_d;
  logic [TOTAL_W-1:0] tot_q, tot_d;
  logic               ovf_q, ovf_d;

  logic [SW-1:0]      stride, width, x_w;
  logic               hit, cont, close1, emit1, close2, emit2;
  logic               open1;
  logic [COL_W-1:0]   start1;
  logic [ROW_W-1:0]   row1;
  logic [LEN_W-1:0]   len1;
  logic [TOTAL_W-1:0] tot1, tot2;
  logic               ovf1, ovf2;
  logic [COL_W-1:0]   col_nx;
  logic [ROW_W-1:0]   row_nx;
  span_result_t       res_a, res_b, res_s;
  logic [1:0]         n;

  always_comb begin
    if (cfg_i.row_stride == 11'd0) begin
      stride = SW'(1);
    end else if (SW'(cfg_i.row_stride) > MAXC) begin
      stride = MAXC;
    end else begin
      stride = SW'(cfg_i.row_stride);
    end
    width = (cfg_i.visible_width == 11'd0) ? stride : SW'(cfg_i.visible_width);
  end

  assign x_w  = SW'(col_q);
  assign hit  = (x_w < width) && cmp_i.diff;
  assign cont = (row_q == rrow_q) && ((CW'(rstart_q) + CW'(rlen_q)) == CW'(col_q));

  // First part: extend, open, or close the run for this cell
  always_comb begin
    close1 = open_q && (!hit || !cont);
    open1  = hit;
    start1 = rstart_q;
    row1   = rrow_q;
    len1   = rlen_q;
    if (hit) begin
      if (open_q && cont) begin
        len1 = rlen_q + LEN_W'(1);
      end else begin
        start1 = col_q;
        row1   = row_q;
        len1   = LEN_W'(1);
      end
    end else begin
      len1 = '0;
    end
    emit1 = close1 && (tot_q < cfg_i.span_cap);
    tot1  = tot_q + TOTAL_W'(emit1);
    ovf1  = ovf_q || (close1 && !emit1);
    // end-of-frame flush
    close2 = cmp_i.final_cell && open1;
    emit2  = close2 && (tot1 < cfg_i.span_cap);
    tot2   = tot1 + TOTAL_W'(emit2);
    ovf2   = ovf1 || (close2 && !emit2);
  end

  always_comb begin
    if ((x_w + SW'(1)) >= stride) begin
      col_nx = '0;
      row_nx = (row_q == ROW_LAST) ? '0 : row_q + ROW_W'(1);
    end else begin
      col_nx = col_q + COL_W'(1);
      row_nx = row_q;
    end
  end

  always_comb begin
    res_a               = '0;
    res_a.result_kind   = RESULT_SPAN;
    res_a.span_column   = OUT_COL_W'(rstart_q);
    res_a.span_row      = OUT_ROW_W'(rrow_q);
    res_a.span_length   = OUT_LEN_W'(rlen_q);
    res_b               = '0;
    res_b.result_kind   = RESULT_SPAN;
    res_b.span_column   = OUT_COL_W'(start1);
    res_b.span_row      = OUT_ROW_W'(row1);
    res_b.span_length   = OUT_LEN_W'(len1);
    res_s               = '0;
    res_s.result_kind   = RESULT_SUMMARY;
    res_s.spans_emitted = tot2;
    res_s.overflowed    = ovf2;

    bundle_o = '0;
    n        = 2'd0;
    if (emit1) begin
      bundle_o.slot[n] = res_a;
      n                = n + 2'd1;
    end
    if (emit2) begin
      bundle_o.slot[n] = res_b;
      n                = n + 2'd1;
    end
    if (cmp_i.final_cell) begin
      bundle_o.slot[n] = res_s;
      n                = n + 2'd1;
    end
    if (n != 2'd0) begin
      bundle_o.slot[n - 2'd1].last_of_run = 1'b1;
    end
    bundle_o.count = n;
  end

  always_comb begin
    col_d    = col_q;
    row_d    = row_q;
    open_d   = open_q;
    rstart_d = rstart_q;
    rrow_d   = rrow_q;
    rlen_d   = rlen_q;
    tot_d    = tot_q;
    ovf_d    = ovf_q;
    if (cmp_i.adv) begin
      if (cmp_i.final_cell) begin
        col_d    = '0;
        row_d    = '0;
        open_d   = 1'b0;
        rstart_d = '0;
        rrow_d   = '0;
        rlen_d   = '0;
        tot_d    = '0;
        ovf_d    = 1'b0;
      end else begin
        col_d    = col_nx;
        row_d    = row_nx;
        open_d   = open1;
        rstart_d = start1;
        rrow_d   = row1;
        rlen_d   = len1;
        tot_d    = tot1;
        ovf_d    = ovf1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q    <= '0;
      row_q    <= '0;
      open_q   <= 1'b0;
      rstart_q <= '0;
      rrow_q   <= '0;
      rlen_q   <= '0;
      tot_q    <= '0;
      ovf_q    <= 1'b0;
    end else begin
      col_q    <= col_d;
      row_q    <= row_d;
      open_q   <= open_d;
      rstart_q <= rstart_d;
      rrow_q   <= rrow_d;
      rlen_q   <= rlen_d;
      tot_q    <= tot_d;
      ovf_q    <= ovf_d;
    end
  end

endmodule

/* rtl/core/cgds_obuf.sv */
// Result buffer: up to three results of one item, drained in order.
module cgds_obuf (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  cgds_pkg::res_bundle_t bundle_i,
  input  logic                  load_i,
  output logic                  room_o,
  cgds_span_if.source           span_o
);
  import cgds_pkg::*;

  logic [1:0]         n_q, n_d;
  span_result_t [2:0] slot_q, slot_d;
  logic               pop;

  assign pop    = span_o.valid && span_o.ready;
  assign room_o = (n_q == 2'd0) || ((n_q == 2'd1) && pop);

  always_comb begin
    n_d    = n_q;
    slot_d = slot_q;
    if (load_i) begin
      n_d    = bundle_i.count;
      slot_d = bundle_i.slot;
    end else if (pop) begin
      n_d       = n_q - 2'd1;
      slot_d[0] = slot_q[1];
      slot_d[1] = slot_q[2];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_q <= 2'd0;
    end else begin
      n_q <= n_d;
    end
  end

  always_ff @(posedge clk_i) begin
    slot_q <= slot_d;
  end

  assign span_o.valid = (n_q != 2'd0);
  assign span_o.data  = slot_q[0];

endmodule

/* rtl/core/cell_grid_dirty_span_finder_core.sv */
// Top level of the character-cell dirty span finder.
//
//   channel   dir  handshake      payload
//   cell_i    in   valid/ready    cell_pair_t (new and old cell, final flag)
//   span_o    out  valid/ready    span_result_t (span or frame summary)
//   cfg_*     in   write enable   register index and data, no read-back
//
// One cell per cycle while the result buffer has room: compare register, then
// run update into the result buffer. A cell causes 0 to 3 results; the output
// drains one per ready cycle, and an item with more than one result holds the input.
// Reset is asynchronous and clears counters, run state and buffer fill.
// The input stalls only when the buffer cannot take the next item's results.
module cell_grid_dirty_span_finder_core #(
  parameter int MAX_COLUMNS = cgds_pkg::MAX_COLUMNS_DEF,
  parameter int MAX_ROWS    = cgds_pkg::MAX_ROWS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  cgds_cell_if.sink                         cell_i,
  cgds_span_if.source                       span_o,
  input  logic                              cfg_we_i,
  input  logic [cgds_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [cgds_pkg::CFG_DATA_W-1:0]   cfg_wdata_i
);
  import cgds_pkg::*;

  `include "cell_grid_dirty_span_finder_core_assert.svh"

  cfg_t        cfg_q, cfg_d;
  cmp_t        cmp;
  res_bundle_t bundle;
  logic        room;

  // Config registers: the user must write them only while idle; the block does not enforce it
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_ROW_STRIDE:    cfg_d.row_stride    = cfg_wdata_i[10:0];
        CFG_VISIBLE_WIDTH: cfg_d.visible_width = cfg_wdata_i[10:0];
        CFG_SPAN_CAP:      cfg_d.span_cap      = cfg_wdata_i[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.row_stride    <= ROW_STRIDE_RST;
      cfg_q.visible_width <= VISIBLE_WIDTH_RST;
      cfg_q.span_cap      <= SPAN_CAP_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Stage 1: cell compare into input register
  cgds_cmp u_cmp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cell_i (cell_i),
    .room_i (room),
    .cmp_o  (cmp)
  );

  // Stage 2: run tracking and result list
  cgds_run #(
    .MAX_COLUMNS (MAX_COLUMNS),
    .MAX_ROWS    (MAX_ROWS)
  ) u_run (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmp_i    (cmp),
    .cfg_i    (cfg_q),
    .bundle_o (bundle)
  );

  // Result buffer in front of the output
  cgds_obuf u_obuf (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .bundle_i (bundle),
    .load_i   (cmp.adv),
    .room_o   (room),
    .span_o   (span_o)
  );

  `CGDS_ASSERT_IMPL(a_final_gives_result, clk_i, rst_ni, cmp.adv && cmp.final_cell, bundle.count != 2'd0, "final cell produced no summary")
  `CGDS_ASSERT_IMPL(a_summary_is_last, clk_i, rst_ni, span_o.valid && (span_o.data.result_kind == RESULT_SUMMARY), span_o.data.last_of_run, "summary not marked last")
  `CGDS_ASSERT_IMPL(a_span_nonempty, clk_i, rst_ni, span_o.valid && (span_o.data.result_kind == RESULT_SPAN), span_o.data.span_length != '0, "empty span emitted")
  `CGDS_ASSERT_NEXT(a_load_shows_result, clk_i, rst_ni, cmp.adv && (bundle.count != 2'd0), span_o.valid, "loaded result not presented")

endmodule

/* dv/tb_top.sv */
// Self-checking testbench for the cell grid dirty span finder core.
`timescale 1ns / 1ps

module tb_top;
  import cgds_pkg::*;

  // Cycles the receiver holds off in the back-pressure phase.
  localparam int STALL_CYCLES = 300;
  // Compare stage plus run update, with spare margin on top.
  localparam int DRAIN_CYCLES = 8;
  // Cycles with no item moved on either channel before giving up.
  localparam int WATCHDOG_LIMIT = 2000;

  // Which attribute of the old cell is disturbed when a pair is made dirty.
  typedef enum int {
    DIFF_CODE, DIFF_FG, DIFF_BG, DIFF_ATTR, DIFF_WIDTH, DIFF_ALL
  } diff_field_e;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  // Configuration port, driven only from the sequencing initial block.
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  // Channel drive registers; each has exactly one procedural driver.
  logic       drv_valid = 1'b0;
  cell_pair_t drv_cell = '0;
  logic       drv_ready = 1'b0;

  cgds_cell_if cell_ch ();
  cgds_span_if span_ch ();

  assign cell_ch.valid = drv_valid;
  assign cell_ch.data  = drv_cell;
  assign span_ch.ready = drv_ready;

  cell_grid_dirty_span_finder_core DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cell_i      (cell_ch),
    .span_o      (span_ch),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  always #5 clk_i = ~clk_i;

  // Traffic shaping, set by the sequencer while the block is idle.
  int cell_gap_pct = 0;
  int result_stall_pct = 0;
  logic stall_request = 1'b0;
  logic stall_taken = 1'b0;
  int stall_left = 0;

  cell_pair_t   cells_to_send[$];
  span_result_t expected_spans[$];
  int mismatch_count = 0;
  int quiet_cycles = 0;

  // ---------------------------------------------------------------------------
  // Span tracker: register copies and frame state at the block's widths.
  // ---------------------------------------------------------------------------
  logic [10:0] cfg_stride = ROW_STRIDE_RST;
  logic [10:0] cfg_width = VISIBLE_WIDTH_RST;
  logic [15:0] cfg_span_cap = SPAN_CAP_RST;

  logic [9:0]  col_pos = '0;
  logic [9:0]  row_pos = '0;
  bit          run_active = 1'b0;
  logic [9:0]  run_col = '0;
  logic [9:0]  run_row_no = '0;
  logic [10:0] run_len = '0;
  logic [15:0] spans_out = '0;
  bit          overflow_flag = 1'b0;

  // Ends the open run; returns 1 when a span comes out of it, else marks overflow.
  function automatic bit retire_run(output span_result_t r);
    r = '0;
    if (spans_out < cfg_span_cap) begin
      r.result_kind = RESULT_SPAN;
      r.span_column = run_col;
      r.span_row    = run_row_no;
      r.span_length = run_len;
      spans_out     = spans_out + 16'd1;
      return 1'b1;
    end
    overflow_flag = 1'b1;
    return 1'b0;
  endfunction

  // Works out the spans and summary one accepted cell pair causes.
  function automatic void track_dirty_runs(cell_pair_t c);
    span_result_t out [3];
    int  k;
    int  stride;
    int  width;
    int  x;
    int  y;
    bit  differs;
    k = 0;
    stride = int'(cfg_stride);
    if (stride == 0) stride = 1;
    if (stride > MAX_COLUMNS_DEF) stride = MAX_COLUMNS_DEF;
    width = (cfg_width == '0) ? stride : int'(cfg_width);
    x = int'(col_pos);
    y = int'(row_pos);
    differs = c.new_code_point != c.old_code_point
           || c.new_foreground != c.old_foreground
           || c.new_background != c.old_background
           || c.new_attributes != c.old_attributes
           || c.new_cell_width != c.old_cell_width;

    if (x >= width || !differs) begin
      // hidden column or clean cell closes the run
      if (run_active) begin
        if (retire_run(out[k])) k++;
        run_active = 1'b0;
        run_len = '0;
      end
    end else if (!run_active) begin
      run_active = 1'b1;
      run_col = x[9:0];
      run_row_no = y[9:0];
      run_len = 11'd1;
    end else if (y == int'(run_row_no) && x == int'(run_col) + int'(run_len)) begin
      run_len = run_len + 11'd1;
    end else begin
      // dirty but not adjacent (new row): close and restart here
      if (retire_run(out[k])) k++;
      run_col = x[9:0];
      run_row_no = y[9:0];
      run_len = 11'd1;
    end

    // column counter wraps at the stride, row counter at MAX_ROWS
    if (x + 1 >= stride) begin
      col_pos = '0;
      row_pos = (y + 1 >= MAX_ROWS_DEF) ? 10'd0 : 10'(y + 1);
    end else begin
      col_pos = 10'(x + 1);
    end

    if (c.final_cell) begin
      if (run_active) begin
        if (retire_run(out[k])) k++;
      end
      out[k] = '0;
      out[k].result_kind = RESULT_SUMMARY;
      out[k].spans_emitted = spans_out;
      out[k].overflowed = overflow_flag;
      k++;
      col_pos = '0;
      row_pos = '0;
      run_active = 1'b0;
      run_col = '0;
      run_row_no = '0;
      run_len = '0;
      spans_out = '0;
      overflow_flag = 1'b0;
    end

    if (k > 0) out[k-1].last_of_run = 1'b1;
    for (int i = 0; i < k; i++) expected_spans.push_back(out[i]);
  endfunction

  // ---------------------------------------------------------------------------
  // Cell pair builders
  // ---------------------------------------------------------------------------
  function automatic cell_pair_t make_pair(diff_field_e f, bit dirty, bit last);
    cell_pair_t c;
    c.new_code_point = $urandom;
    c.new_foreground = $urandom;
    c.new_background = $urandom;
    c.new_attributes = 16'($urandom);
    c.new_cell_width = 8'($urandom);
    c.old_code_point = c.new_code_point;
    c.old_foreground = c.new_foreground;
    c.old_background = c.new_background;
    c.old_attributes = c.new_attributes;
    c.old_cell_width = c.new_cell_width;
    c.final_cell = last;
    if (dirty) begin
      // single-bit flips keep most of the pair equal, which is the hard case
      case (f)
        DIFF_CODE:  c.old_code_point ^= 32'd1 << $urandom_range(31);
        DIFF_FG:    c.old_foreground ^= 32'd1 << $urandom_range(31);
        DIFF_BG:    c.old_background ^= 32'd1 << $urandom_range(31);
        DIFF_ATTR:  c.old_attributes ^= 16'd1 << $urandom_range(15);
        DIFF_WIDTH: c.old_cell_width ^= 8'd1 << $urandom_range(7);
        default: begin
          c.old_code_point = $urandom;
          c.old_foreground = $urandom;
          c.old_background = $urandom;
          c.old_attributes = 16'($urandom);
          c.old_cell_width = ~c.new_cell_width;
        end
      endcase
    end
    return c;
  endfunction

  // Difference in one attribute only, new side all ones and old side all zeros.
  function automatic cell_pair_t extreme_pair(diff_field_e f);
    cell_pair_t c;
    c = make_pair(f, 1'b0, 1'b0);
    case (f)
      DIFF_CODE:  begin c.new_code_point = '1; c.old_code_point = '0; end
      DIFF_FG:    begin c.new_foreground = '1; c.old_foreground = '0; end
      DIFF_BG:    begin c.new_background = '1; c.old_background = '0; end
      DIFF_ATTR:  begin c.new_attributes = '1; c.old_attributes = '0; end
      default:    begin c.new_cell_width = '1; c.old_cell_width = '0; end
    endcase
    return c;
  endfunction

  // Random cells in dirty streaks with the odd frame end.
  task automatic queue_random_cells(input int n);
    bit dirty;
    bit last;
    dirty = 1'b0;
    for (int i = 0; i < n; i++) begin
      dirty = dirty ? ($urandom_range(99) < 75) : ($urandom_range(99) < 35);
      last = ($urandom_range(29) == 0);
      cells_to_send.push_back(make_pair(diff_field_e'($urandom_range(5)), dirty, last));
    end
  endtask

  // ---------------------------------------------------------------------------
  // Register writes (only while the block is idle)
  // ---------------------------------------------------------------------------
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
    @(posedge clk_i);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= val[CFG_DATA_W-1:0];
    @(posedge clk_i);
    cfg_we <= 1'b0;
    case (idx)
      CFG_ROW_STRIDE:    cfg_stride = val[10:0];
      CFG_VISIBLE_WIDTH: cfg_width = val[10:0];
      CFG_SPAN_CAP:      cfg_span_cap = val[15:0];
      default: ;
    endcase
  endtask

  task automatic set_regs(input int unsigned stride, input int unsigned width,
                          input int unsigned spans);
    write_reg(CFG_ROW_STRIDE, stride);
    write_reg(CFG_VISIBLE_WIDTH, width);
    write_reg(CFG_SPAN_CAP, spans);
  endtask

  task automatic random_regs();
    int unsigned stride;
    int unsigned width;
    int unsigned spans;
    case ($urandom_range(9))
      0:       stride = 0;
      1:       stride = 2047;
      2:       stride = $urandom_range(13, 1024);
      default: stride = $urandom_range(1, 12);
    endcase
    case ($urandom_range(5))
      0, 1:    width = 0;
      2:       width = $urandom_range(0, 1024);
      default: width = $urandom_range(1, 14);
    endcase
    spans = ($urandom_range(9) < 4) ? $urandom_range(0, 3) : $urandom_range(0, 65535);
    set_regs(stride, width, spans);
  endtask

  // Wait until every cell is in and every expected result is out, then let the
  // pipeline run dry so a cell with no result cannot straddle a register write.
  task automatic settle();
    while (cells_to_send.size() != 0 || drv_valid || expected_spans.size() != 0)
      @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // Cell driver: offers queued cells, predicts on acceptance.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      drv_valid <= 1'b0;
    end else begin
      if (drv_valid && cell_ch.ready) track_dirty_runs(drv_cell);
      // slot is free when nothing is offered or the offer was just taken
      if (!drv_valid || cell_ch.ready) begin
        if (cells_to_send.size() != 0 && $urandom_range(99) >= cell_gap_pct) begin
          drv_valid <= 1'b1;
          drv_cell <= cells_to_send.pop_front();
        end else begin
          drv_valid <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-off, armed once by the sequencer.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      stall_left <= 0;
      stall_taken <= 1'b0;
    end else if (stall_request && !stall_taken) begin
      stall_left <= STALL_CYCLES;
      stall_taken <= 1'b1;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end
  end

  // Result receiver with random back-pressure.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      drv_ready <= 1'b0;
    end else begin
      drv_ready <= (stall_left == 0) && ($urandom_range(99) >= result_stall_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Result monitor: in-order compare against the expected spans.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    span_result_t want;
    span_result_t got;
    if (rst_ni && span_ch.valid && drv_ready) begin
      got = span_ch.data;
      if (expected_spans.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("%0t unexpected result: kind %0d col %0d row %0d len %0d total %0d",
                   $realtime, got.result_kind, got.span_column, got.span_row,
                   got.span_length, got.spans_emitted);
      end else begin
        want = expected_spans.pop_front();
        if (got.result_kind !== want.result_kind || got.span_column !== want.span_column
            || got.span_row !== want.span_row || got.span_length !== want.span_length
            || got.spans_emitted !== want.spans_emitted
            || got.overflowed !== want.overflowed
            || got.last_of_run !== want.last_of_run) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("%0t mismatch exp: kind %0d col %0d row %0d len %0d total %0d ovf %0d last %0d",
                     $realtime, want.result_kind, want.span_column, want.span_row,
                     want.span_length, want.spans_emitted, want.overflowed, want.last_of_run);
            $display("%0t          got: kind %0d col %0d row %0d len %0d total %0d ovf %0d last %0d",
                     $realtime, got.result_kind, got.span_column, got.span_row,
                     got.span_length, got.spans_emitted, got.overflowed, got.last_of_run);
          end
        end
      end
    end
  end

  // Watchdog: ends a run in which neither channel moves for too long.
  always @(posedge clk_i) begin
    if ((drv_valid && cell_ch.ready) || (span_ch.valid && drv_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no item moved for %0d cycles", quiet_cycles);
      $display("RESULT: ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  initial begin
    cell_pair_t c;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    cell_gap_pct = 29;
    result_stall_pct = 45;

    // Reset register values: clean cells at both extremes, then one dirty run
    // built from a full-scale difference in each attribute, closed by a clean
    // cell, and a lone dirty cell flushed by the frame end.
    c = '0;
    cells_to_send.push_back(c);
    c = '1;
    c.final_cell = 1'b0;
    cells_to_send.push_back(c);
    cells_to_send.push_back(extreme_pair(DIFF_CODE));
    cells_to_send.push_back(extreme_pair(DIFF_FG));
    cells_to_send.push_back(extreme_pair(DIFF_BG));
    cells_to_send.push_back(extreme_pair(DIFF_ATTR));
    cells_to_send.push_back(extreme_pair(DIFF_WIDTH));
    cells_to_send.push_back(make_pair(DIFF_ALL, 1'b0, 1'b0));
    cells_to_send.push_back(make_pair(DIFF_ALL, 1'b1, 1'b1));
    settle();

    // Stride zero acts as one; no span room at all, so every run overflows.
    set_regs(0, 0, 0);
    cells_to_send.push_back(make_pair(DIFF_CODE, 1'b1, 1'b0));
    cells_to_send.push_back(make_pair(DIFF_FG, 1'b1, 1'b0));
    cells_to_send.push_back(make_pair(DIFF_BG, 1'b0, 1'b0));
    cells_to_send.push_back(make_pair(DIFF_ATTR, 1'b1, 1'b1));
    settle();

    // Visible width past the stride; a run broken by the row change plus the
    // frame end gives three results from one cell.
    set_regs(3, 2047, 65535);
    for (int i = 0; i < 4; i++)
      cells_to_send.push_back(make_pair(DIFF_ALL, 1'b1, i == 3));
    settle();

    // Narrow visible width cuts runs; one span of room, then overflow.
    // Left mid-frame on purpose.
    set_regs(4, 2, 1);
    for (int i = 0; i < 5; i++)
      cells_to_send.push_back(make_pair(DIFF_WIDTH, 1'b1, 1'b0));
    cells_to_send.push_back(make_pair(DIFF_WIDTH, 1'b0, 1'b0));
    settle();

    // Stride shrinks under a column counter already past it.
    set_regs(2, 0, 5);
    cells_to_send.push_back(make_pair(DIFF_ATTR, 1'b1, 1'b0));
    cells_to_send.push_back(make_pair(DIFF_ATTR, 1'b1, 1'b0));
    cells_to_send.push_back(make_pair(DIFF_ATTR, 1'b1, 1'b0));
    cells_to_send.push_back(make_pair(DIFF_ATTR, 1'b1, 1'b1));
    settle();

    // Random part in three traffic stages; back-pressure stall in the last.
    for (int stage = 0; stage < 3; stage++) begin
      case (stage)
        0:       begin cell_gap_pct = 29; result_stall_pct = 45; end
        1:       begin cell_gap_pct = 45; result_stall_pct = 29; end
        default: begin cell_gap_pct = 0;  result_stall_pct = 0;  end
      endcase
      for (int ph = 0; ph < 4; ph++) begin
        if (stage == 2 && ph == 1) begin
          set_regs(4, 0, 65535);
          queue_random_cells(60);
          stall_request = 1'b1;
        end else begin
          random_regs();
          queue_random_cells(24);
        end
        settle();
      end
    end

    if (mismatch_count == 0 && expected_spans.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+rtl/core
rtl/core/cgds_pkg.sv
rtl/core/cgds_if.sv
rtl/core/cgds_cmp.sv
rtl/core/cgds_run.sv
rtl/core/cgds_obuf.sv
rtl/core/cell_grid_dirty_span_finder_core.sv
dv/tb_top.sv
